FILE: design/bqr_pkg.sv
// ----------------------------------------------------------------------------
// Bounded queue with remove: shared package
// Command and status codes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package bqr_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int ITEM_WIDTH_DEF = 32;
  localparam int FILL_W_DEF     = $clog2(DEPTH_DEF + 1);

  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;

  localparam logic [CMD_W-1:0] CMD_INIT    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ENQUEUE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DEQUEUE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DESTROY = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ALREADY  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_INIT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NO_ITEM  = 3'd5;

endpackage

FILE: design/bqr_if.sv
// ----------------------------------------------------------------------------
// Bounded queue with remove: channel interfaces
// Command channel and response channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bqr_cmd_if import bqr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [VALUE_W-1:0] item_value;

  modport source (output valid, output command, output item_value, input ready);
  modport sink (input valid, input command, input item_value, output ready);
endinterface

interface bqr_rsp_if import bqr_pkg::*; #(
  parameter int CNT_W = FILL_W_DEF
) ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  item_out;
  logic [CNT_W-1:0]    fill_count;

  modport source (output valid, output status, output item_out, output fill_count,
                  input ready);
  modport sink (input valid, input status, input item_out, input fill_count,
                output ready);
endinterface

FILE: design/bqr_ram.sv
// ----------------------------------------------------------------------------
// Bounded queue with remove: generic single-port RAM
// One read and/or write per cycle at a single address, read data registered and held between reads.
// ----------------------------------------------------------------------------
module bqr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/bounded_queue_with_remove_core.sv
// Command handling: init, enqueue, dequeue, destroy and rejected commands respond
// from the EXEC state once the response register is free; a remove reads and compares
// entries from the newest down (SRD, SCMP), moves later entries down (HRD, HWR)
// if it finds its item, and responds from FIN. Commands are taken only in IDLE.
// Reset clears the control state; the queue starts not initialized and empty,
// and RAM contents stay undefined until written.
// ----------------------------------------------------------------------------
// Bounded queue with remove: top level
// Circular queue held in a single-port RAM, with a sequencer for the search
// and the compaction that a remove needs.
// ----------------------------------------------------------------------------
module bounded_queue_with_remove_core import bqr_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int ITEM_WIDTH = ITEM_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bqr_cmd_if.sink   cmd_i,
  bqr_rsp_if.source rsp_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = PTR_W + 1;

  localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SRD  = 3'd2;
  localparam logic [2:0] S_SCMP = 3'd3;
  localparam logic [2:0] S_HRD  = 3'd4;
  localparam logic [2:0] S_HWR  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]            state_q, state_d;
  logic [CMD_W-1:0]      cmd_q, cmd_d;
  logic [ITEM_WIDTH-1:0] item_q, item_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [PTR_W-1:0]      head_q, head_d;
  logic                  init_q, init_d;
  logic [PTR_W-1:0]      k_q, k_d;
  logic [PTR_W-1:0]      j_q, j_d;
  logic [STATUS_W-1:0]   fin_q, fin_d;

  logic                  rsp_valid_q, rsp_valid_d;
  logic [STATUS_W-1:0]   rsp_status_q, rsp_status_d;
  logic [VALUE_W-1:0]    rsp_item_q, rsp_item_d;
  logic [CNT_W-1:0]      rsp_fill_q, rsp_fill_d;

  logic                  out_free;
  logic                  emit;
  logic [STATUS_W-1:0]   emit_status;
  logic [VALUE_W-1:0]    emit_item;

  logic [PTR_W-1:0]      lpos;
  logic [SUM_W-1:0]      addr_sum;
  logic [PTR_W-1:0]      ram_addr;
  logic                  ram_re, ram_we;
  logic [ITEM_WIDTH-1:0] ram_wdata, ram_rdata;

  assign out_free = !rsp_valid_q || rsp_o.ready;

  // Logical position to RAM address, wrapping around the circular buffer.
  always_comb begin
    addr_sum = {1'b0, head_q} + {1'b0, lpos};
    if (addr_sum >= DEPTH_S) begin
      addr_sum = addr_sum - DEPTH_S;
    end
    ram_addr = addr_sum[PTR_W-1:0];
  end

  bqr_ram #(
    .WIDTH (ITEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .re_i    (ram_re),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    item_d      = item_q;
    count_d     = count_q;
    head_d      = head_q;
    init_d      = init_q;
    k_d         = k_q;
    j_d         = j_q;
    fin_d       = fin_q;
    lpos        = '0;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    ram_wdata   = item_q;
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_item   = '0;

    case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          cmd_d   = cmd_i.command;
          item_d  = ITEM_WIDTH'(cmd_i.item_value);
          ram_re  = (cmd_i.command == CMD_DEQUEUE);
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        lpos = PTR_W'(count_q);
        if (out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
          case (cmd_q)
            CMD_INIT: begin
              if (init_q) begin
                emit_status = ST_ALREADY;
              end else begin
                init_d  = 1'b1;
                count_d = '0;
              end
            end
            CMD_ENQUEUE: begin
              if (!init_q) begin
                emit_status = ST_NOT_INIT;
              end else if (count_q == DEPTH_C) begin
                emit_status = ST_FULL;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
            end
            CMD_DEQUEUE: begin
              if (!init_q) begin
                emit_status = ST_NOT_INIT;
              end else if (count_q == '0) begin
                emit_status = ST_EMPTY;
              end else begin
                emit_item = VALUE_W'(ram_rdata);
                head_d    = (head_q == LAST_PTR) ? '0 : head_q + PTR_W'(1);
                count_d   = count_q - CNT_W'(1);
              end
            end
            CMD_REMOVE: begin
              if (!init_q) begin
                emit_status = ST_NOT_INIT;
              end else if (count_q == '0) begin
                emit_status = ST_EMPTY;
              end else begin
                emit    = 1'b0;
                k_d     = PTR_W'(count_q - CNT_W'(1));
                state_d = S_SRD;
              end
            end
            CMD_DESTROY: begin
              if (!init_q) begin
                emit_status = ST_NOT_INIT;
              end else begin
                init_d  = 1'b0;
                count_d = '0;
              end
            end
            default: begin
              emit_status = ST_OK;
            end
          endcase
        end
      end
      S_SRD: begin
        lpos    = k_q;
        ram_re  = 1'b1;
        state_d = S_SCMP;
      end
      S_SCMP: begin
        if (ram_rdata == item_q) begin
          j_d     = k_q;
          state_d = S_HRD;
        end else if (k_q == '0) begin
          fin_d   = ST_NO_ITEM;
          state_d = S_FIN;
        end else begin
          k_d     = k_q - PTR_W'(1);
          state_d = S_SRD;
        end
      end
      S_HRD: begin
        lpos = j_q + PTR_W'(1);
        if (CNT_W'(j_q) + CNT_W'(1) == count_q) begin
          fin_d   = ST_OK;
          state_d = S_FIN;
        end else begin
          ram_re  = 1'b1;
          state_d = S_HWR;
        end
      end
      S_HWR: begin
        lpos      = j_q;
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        j_d       = j_q + PTR_W'(1);
        state_d   = S_HRD;
      end
      S_FIN: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_status = fin_q;
          if (fin_q == ST_OK) begin
            count_d = count_q - CNT_W'(1);
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    rsp_valid_d  = rsp_valid_q;
    rsp_status_d = rsp_status_q;
    rsp_item_d   = rsp_item_q;
    rsp_fill_d   = rsp_fill_q;
    if (emit) begin
      rsp_valid_d  = 1'b1;
      rsp_status_d = emit_status;
      rsp_item_d   = emit_item;
      rsp_fill_d   = count_d;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      head_q      <= '0;
      init_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      head_q      <= head_d;
      init_q      <= init_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    item_q       <= item_d;
    k_q          <= k_d;
    j_q          <= j_d;
    fin_q        <= fin_d;
    rsp_status_q <= rsp_status_d;
    rsp_item_q   <= rsp_item_d;
    rsp_fill_q   <= rsp_fill_d;
  end

  assign cmd_i.ready      = (state_q == S_IDLE);
  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = rsp_status_q;
  assign rsp_o.item_out   = rsp_item_q;
  assign rsp_o.fill_count = rsp_fill_q;

endmodule

FILE: design/bqr_chk.sv
// ----------------------------------------------------------------------------
// Bounded queue with remove: port checker
// Watches the command and response beats at the top level's ports.
// ----------------------------------------------------------------------------
module bqr_chk import bqr_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cmd_valid_i,
  input logic                           cmd_ready_i,
  input logic                           rsp_valid_i,
  input logic                           rsp_ready_i,
  input logic [STATUS_W-1:0]            status_i,
  input logic [VALUE_W-1:0]             item_out_i,
  input logic [$clog2(DEPTH + 1)-1:0]   fill_count_i
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("Response beat withdrawn before it was taken.");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |=> !cmd_ready_i)
    else $error("Command taken while the previous one was still in progress.");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> fill_count_i <= CNT_W'(DEPTH))
    else $error("Fill count exceeds the queue depth.");

  a_item_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i != ST_OK |-> item_out_i == '0)
    else $error("Item returned with a failing status.");

  a_not_init_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == ST_NOT_INIT |-> fill_count_i == '0)
    else $error("Queue not initialized but reports entries.");

endmodule

bind bounded_queue_with_remove_core bqr_chk #(
  .DEPTH (DEPTH)
) u_bqr_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cmd_valid_i  (cmd_i.valid),
  .cmd_ready_i  (cmd_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .status_i     (rsp_o.status),
  .item_out_i   (rsp_o.item_out),
  .fill_count_i (rsp_o.fill_count)
);

FILE: dv/tb_bounded_queue_with_remove_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bounded queue with remove: self-checking testbench
// A clocked driver feeds command beats from a queue of planned commands. A clocked
// monitor takes the response beats. Each accepted command is applied to a
// behavioural model of the queue, and the response it predicts is compared
// with the block's response. A directed opening covers every command, the
// error statuses and full occupancy. Random sequences then follow, with random
// gaps on both sides and long response hold-offs that back up the input.
// ----------------------------------------------------------------------------
module tb_bounded_queue_with_remove_core;
  import bqr_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int ITEM_W      = ITEM_WIDTH_DEF;
  localparam int CNT_W       = FILL_W_DEF;
  localparam int MAX_WAIT    = 11;
  localparam int RANDOM_CMDS = 600;
  localparam int HOLD_CYCLES = 200;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 100;

  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [VALUE_W-1:0] value;
  } cmd_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  item_out;
    logic [CNT_W-1:0]    fill_count;
  } rsp_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bqr_cmd_if cmd_if ();
  bqr_rsp_if #(.CNT_W(CNT_W)) rsp_if ();

  bounded_queue_with_remove_core #(
    .DEPTH      (DEPTH),
    .ITEM_WIDTH (ITEM_W)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  cmd_beat_t          planned_cmds[$];
  rsp_beat_t          expected_rsp[$];
  cmd_beat_t          next_cmd;
  rsp_beat_t          seen_rsp;
  rsp_beat_t          want_rsp;
  logic [VALUE_W-1:0] handle_pool[8];

  // Behavioural copy of the queue.
  logic [ITEM_W-1:0] mdl_entries[DEPTH];
  int                mdl_count;
  bit                mdl_ready;

  // Rough shadow used only while planning, to aim removes at held handles.
  logic [VALUE_W-1:0] plan_held[$];
  bit                 plan_ready;

  bit cmd_offer;
  int cmd_gap;
  int rsp_wait;
  bit rsp_hold;
  bit calm_phase;
  int cmd_beats;
  int rsp_beats;
  int err_count;
  int full_hits;
  int remove_hits;
  int dequeue_hits;

  function automatic int draw_wait();
    return calm_phase ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic void close_gap(input int pos);
    for (int i = pos; i + 1 < mdl_count; i++) begin
      mdl_entries[i] = mdl_entries[i + 1];
    end
    if (mdl_count > 0) mdl_count--;
  endfunction

  function automatic rsp_beat_t queue_model_step(input logic [CMD_W-1:0] cmd,
                                                 input logic [VALUE_W-1:0] value);
    rsp_beat_t         r;
    logic [ITEM_W-1:0] handle;
    int                k;
    bit                found;
    r.status   = ST_OK;
    r.item_out = '0;
    handle     = value[ITEM_W-1:0];
    found      = 1'b0;
    if (cmd == CMD_INIT) begin
      if (mdl_ready) begin
        r.status = ST_ALREADY;
      end else begin
        mdl_ready = 1'b1;
        mdl_count = 0;
      end
    end else if (cmd <= CMD_DESTROY && !mdl_ready) begin
      r.status = ST_NOT_INIT;
    end else begin
      case (cmd)
        CMD_ENQUEUE: begin
          if (mdl_count >= DEPTH) begin
            r.status = ST_FULL;
            full_hits++;
          end else begin
            mdl_entries[mdl_count] = handle;
            mdl_count++;
          end
        end
        CMD_DEQUEUE: begin
          if (mdl_count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.item_out = VALUE_W'(mdl_entries[0]);
            close_gap(0);
            dequeue_hits++;
          end
        end
        CMD_REMOVE: begin
          if (mdl_count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            k = mdl_count;
            while (k > 0 && !found) begin
              k--;
              found = (mdl_entries[k] == handle);
            end
            if (found) begin
              close_gap(k);
              remove_hits++;
            end else begin
              r.status = ST_NO_ITEM;
            end
          end
        end
        CMD_DESTROY: begin
          mdl_count = 0;
          mdl_ready = 1'b0;
        end
        default: ;
      endcase
    end
    r.fill_count = CNT_W'(mdl_count);
    return r;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_handle();
    if ($urandom_range(0, 9) < 4) return handle_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  task automatic plan_command(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value);
    cmd_beat_t b;
    int        k;
    b.command = cmd;
    b.value   = value;
    planned_cmds.push_back(b);
    if (cmd == CMD_INIT && !plan_ready) begin
      plan_ready = 1'b1;
      plan_held.delete();
    end else if (plan_ready) begin
      case (cmd)
        CMD_ENQUEUE: if (plan_held.size() < DEPTH) plan_held.push_back(value);
        CMD_DEQUEUE: if (plan_held.size() > 0) void'(plan_held.pop_front());
        CMD_REMOVE: begin
          k = plan_held.size();
          while (k > 0) begin
            k--;
            if (plan_held[k] == value) begin
              plan_held.delete(k);
              k = 0;
            end
          end
        end
        CMD_DESTROY: begin
          plan_ready = 1'b0;
          plan_held.delete();
        end
        default: ;
      endcase
    end
  endtask

  // Command driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_if.valid      <= 1'b0;
      cmd_if.command    <= CMD_INIT;
      cmd_if.item_value <= '0;
      cmd_offer = 1'b0;
      cmd_gap   = 0;
    end else begin
      if (cmd_offer && cmd_if.ready) begin
        expected_rsp.push_back(queue_model_step(cmd_if.command, cmd_if.item_value));
        cmd_beats++;
        cmd_offer = 1'b0;
        cmd_gap   = draw_wait();
      end
      if (!cmd_offer) begin
        if (cmd_gap > 0) begin
          cmd_gap--;
        end else if (planned_cmds.size() > 0) begin
          next_cmd = planned_cmds.pop_front();
          cmd_if.command    <= next_cmd.command;
          cmd_if.item_value <= next_cmd.value;
          cmd_offer = 1'b1;
        end
      end
      cmd_if.valid <= cmd_offer;
    end
  end

  // Response monitor and checker.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      rsp_wait = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        seen_rsp.status     = rsp_if.status;
        seen_rsp.item_out   = rsp_if.item_out;
        seen_rsp.fill_count = rsp_if.fill_count;
        rsp_beats++;
        if (expected_rsp.size() == 0) begin
          $error("response beat with no command outstanding");
          err_count++;
        end else begin
          want_rsp = expected_rsp.pop_front();
          if (seen_rsp.status !== want_rsp.status) begin
            $error("status mismatch: expected %0d, actual %0d", want_rsp.status,
                   seen_rsp.status);
            err_count++;
          end
          if (seen_rsp.item_out !== want_rsp.item_out) begin
            $error("item_out mismatch: expected 0x%08h, actual 0x%08h", want_rsp.item_out,
                   seen_rsp.item_out);
            err_count++;
          end
          if (seen_rsp.fill_count !== want_rsp.fill_count) begin
            $error("fill_count mismatch: expected %0d, actual %0d", want_rsp.fill_count,
                   seen_rsp.fill_count);
            err_count++;
          end
        end
        rsp_wait = draw_wait();
      end
      if (rsp_wait > 0) begin
        rsp_wait--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= !rsp_hold;
      end
    end
  end

  always @(posedge clk_i) begin
    if ($urandom_range(0, 255) == 0) calm_phase <= ($urandom_range(0, 2) == 0);
  end

  // Response hold-off: the sink stops taking beats so that the block backs up.
  initial begin
    rsp_hold = 1'b0;
    wait (cmd_beats >= 150);
    @(posedge clk_i);
    rsp_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rsp_hold <= 1'b0;
    wait (cmd_beats >= 450);
    @(posedge clk_i);
    rsp_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rsp_hold <= 1'b0;
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (planned_cmds.size() == 0 && !cmd_offer && expected_rsp.size() == 0)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("No handshake for %0d cycles; run abandoned.", STALL_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int                 counted;
    int                 enq_weight;
    int                 r;
    logic [VALUE_W-1:0] v;
    rst_ni            = 1'b0;
    cmd_if.valid      = 1'b0;
    cmd_if.command    = CMD_INIT;
    cmd_if.item_value = '0;
    rsp_if.ready      = 1'b0;
    calm_phase        = 1'b0;
    cmd_beats         = 0;
    rsp_beats         = 0;
    err_count         = 0;
    full_hits         = 0;
    remove_hits       = 0;
    dequeue_hits      = 0;
    mdl_count         = 0;
    mdl_ready         = 1'b0;
    plan_ready        = 1'b0;
    foreach (mdl_entries[i]) mdl_entries[i] = '0;
    handle_pool[0] = '0;
    handle_pool[1] = '1;
    for (int i = 2; i < 8; i++) handle_pool[i] = $urandom();

    // Directed opening.
    plan_command(CMD_ENQUEUE, 32'h0000_1234);
    plan_command(CMD_DEQUEUE, '0);
    plan_command(CMD_REMOVE, 32'h0000_1234);
    plan_command(CMD_DESTROY, '0);
    plan_command(CMD_SPARE_C, '1);
    plan_command(CMD_INIT, '0);
    plan_command(CMD_INIT, '0);
    plan_command(CMD_DEQUEUE, '0);
    plan_command(CMD_REMOVE, '1);
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0) v = '0;
      else if (i == 1) v = '1;
      else if (i == 3 || i == 10) v = 32'hA5A5_5A5A;
      else v = handle_pool[i % 8] ^ VALUE_W'(i);
      plan_command(CMD_ENQUEUE, v);
    end
    plan_command(CMD_ENQUEUE, 32'h5555_AAAA);
    plan_command(CMD_REMOVE, 32'hA5A5_5A5A);
    plan_command(CMD_REMOVE, 32'hDEAD_BEEF);
    plan_command(CMD_SPARE_A, 32'hFFFF_0000);
    plan_command(CMD_DEQUEUE, '0);
    plan_command(CMD_REMOVE, '1);
    plan_command(CMD_SPARE_B, 32'h0000_FFFF);
    plan_command(CMD_DESTROY, '0);
    plan_command(CMD_DESTROY, '0);

    // Random sequences: mostly well-formed traffic with a drifting fill bias.
    counted    = 0;
    enq_weight = 50;
    while (counted < RANDOM_CMDS) begin
      if (counted % 40 == 0) enq_weight = 25 * $urandom_range(1, 3);
      if (!plan_ready) begin
        if ($urandom_range(0, 9) < 8) plan_command(CMD_INIT, $urandom());
        else plan_command(CMD_W'($urandom_range(CMD_ENQUEUE, CMD_DESTROY)), pick_handle());
        counted++;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          plan_command(CMD_DESTROY, $urandom());
          counted++;
        end else if (r < 4) begin
          plan_command(CMD_INIT, $urandom());
          counted++;
        end else if (r < 7) begin
          plan_command(CMD_W'($urandom_range(CMD_SPARE_A, CMD_SPARE_C)), $urandom());
        end else begin
          r = $urandom_range(0, 99);
          if (r < enq_weight) begin
            plan_command(CMD_ENQUEUE, pick_handle());
          end else if (r < enq_weight + (100 - enq_weight) / 2) begin
            plan_command(CMD_DEQUEUE, $urandom());
          end else if (plan_held.size() > 0 && $urandom_range(0, 9) < 7) begin
            plan_command(CMD_REMOVE, plan_held[$urandom_range(0, plan_held.size() - 1)]);
          end else begin
            plan_command(CMD_REMOVE, pick_handle());
          end
          counted++;
        end
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (planned_cmds.size() == 0 && !cmd_offer && expected_rsp.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Checked %0d response beats against %0d command beats.", rsp_beats, cmd_beats);
    $display("Full rejections %0d, removes that found their handle %0d, dequeues %0d.",
             full_hits, remove_hits, dequeue_hits);
    if (err_count == 0 && expected_rsp.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/bqr_pkg.sv
design/bqr_if.sv
design/bqr_ram.sv
design/bounded_queue_with_remove_core.sv
design/bqr_chk.sv
dv/tb_bounded_queue_with_remove_core.sv
